FILE: rtl/srbp_pkg.sv
// Package with the codes, tables and constants of the stepper ramp bin positioner.
package srbp_pkg;

    // Input item kinds, carried on s_tuser.
    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_MOVE   = 2'd1,
        KIND_HOME   = 2'd2,
        KIND_SENSOR = 2'd3
    } kind_t;

    // Run mode, one-hot.
    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_MOVE = 3'b010,
        MODE_HOME = 3'b100
    } mode_t;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_QUARTER_STEPS = 2'd0,
        REG_HALF_STEPS    = 2'd1,
        REG_BELT_LEAD     = 2'd2,
        REG_HOME_DELAY    = 2'd3
    } reg_index_t;

    // Register reset values.
    localparam logic [7:0] QUARTER_STEPS_RST = 8'd50;
    localparam logic [7:0] HALF_STEPS_RST    = 8'd100;
    localparam logic [7:0] BELT_LEAD_RST     = 8'd36;
    localparam logic [8:0] HOME_DELAY_RST    = 9'd20;

    // Ramp shape.
    localparam int unsigned ACCEL_TABLE_LEN = 20;
    localparam int unsigned DECEL_TABLE_LEN = 10;
    localparam int unsigned ACCEL_IDX_W     = $clog2(ACCEL_TABLE_LEN);
    localparam logic [7:0]  ACCEL_STEPS     = 8'd18;
    localparam logic [7:0]  DECEL_WINDOW    = 8'd10;
    localparam logic [8:0]  CRUISE_DELAY    = 9'd100;
    localparam logic [3:0]  DECEL_IDX_MAX   = 4'd15;
    localparam logic [3:0]  DECEL_IDX_LAST  = 4'(DECEL_TABLE_LEN - 1);

    // Coil drive pattern for each of the four phases.
    localparam logic [5:0] COIL_TABLE [4] = '{6'b110110, 6'b101110, 6'b101101, 6'b110101};

    // Wait in ticks after each step of the acceleration and deceleration ramps.
    localparam logic [8:0] ACCEL_TABLE [ACCEL_TABLE_LEN] = '{
        9'd340, 9'd320, 9'd300, 9'd280, 9'd260, 9'd240, 9'd220, 9'd200, 9'd180, 9'd160,
        9'd140, 9'd120, 9'd110, 9'd100, 9'd100, 9'd100, 9'd100, 9'd100, 9'd100, 9'd100};
    localparam logic [8:0] DECEL_TABLE [DECEL_TABLE_LEN] = '{
        9'd100, 9'd120, 9'd150, 9'd180, 9'd210, 9'd240, 9'd270, 9'd300, 9'd330, 9'd360};

endpackage

FILE: rtl/stepper_ramp_bin_positioner_unit.sv
// Top level of the stepper ramp bin positioner: command decode, step sequencer and result buffer.

// The block takes one beat per clock cycle: ticks, move commands, homing commands and
// sensor events all update the stepper state in the cycle they are accepted, and a step
// beat is registered into the two-entry output buffer in the cycle after. s_tready drops only while
// both output slots are full, so input flow stops only under sustained back pressure.
// Configuration is written over the APB port; the user must write it only while no run is active,
// and the block itself does not enforce this. A move picks a quarter turn counter-clockwise, a quarter
// turn clockwise or a half turn clockwise, and homing steps clockwise until a sensor event has been seen.
module stepper_ramp_bin_positioner_unit
    import srbp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [1:0] target_bin, [7:2] zero
    input  logic [1:0]  s_tuser,   // [1:0] kind
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] coil_pattern, [6] belt_start, [8:7] bin_now, [15:9] zero
    output logic        m_tlast,   // last_step
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers.
    logic [7:0] quarter_steps_reg;
    logic [7:0] half_steps_reg;
    logic [7:0] belt_lead_reg;
    logic [8:0] home_delay_reg;

    // Stepper state.
    logic [1:0] phase_reg, phase_next;
    logic [1:0] bin_reg, bin_next;
    logic       home_seen_reg, home_seen_next;
    mode_t      mode_reg, mode_next;
    logic       dir_reg, dir_next;
    logic [7:0] steps_total_reg, steps_total_next;
    logic [7:0] step_count_reg, step_count_next;
    logic [3:0] decel_idx_reg, decel_idx_next;
    logic [8:0] wait_reg, wait_next;

    // Result of the accepted beat.
    logic       res_valid;
    logic [5:0] res_coil;
    logic       res_belt;
    logic       res_last;
    logic [1:0] res_bin;

    // Output buffer: main slot and skid slot.
    logic       out_valid_reg;
    logic [5:0] out_coil_reg;
    logic       out_belt_reg;
    logic       out_last_reg;
    logic [1:0] out_bin_reg;
    logic       skid_valid_reg;
    logic [5:0] skid_coil_reg;
    logic       skid_belt_reg;
    logic       skid_last_reg;
    logic [1:0] skid_bin_reg;

    logic       s_accept;
    logic       m_pop;
    logic       cfg_write;
    kind_t      kind;
    logic [1:0] target;
    logic [1:0] diff;
    logic       new_dir;
    logic [7:0] new_total;
    logic       is_new_move;

    // Operands of a move step, either from the new command or from the running move.
    logic       mv_dir;
    logic [7:0] mv_total;
    logic [7:0] mv_count;
    logic [3:0] mv_decel;
    logic [7:0] mv_left;
    logic [3:0] dec_k;
    logic [8:0] mv_wait;
    logic       mv_in_decel;
    logic [1:0] mv_phase;
    logic [1:0] home_phase;

    assign s_tready  = !skid_valid_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign m_pop     = out_valid_reg && m_tready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign kind      = kind_t'(s_tuser);
    assign target    = s_tdata[1:0];

    // Direction and length of a move from the ring distance to the target.
    assign diff        = target - bin_reg;
    assign new_dir     = (diff != 2'd1);
    assign new_total   = (diff == 2'd2) ? half_steps_reg : quarter_steps_reg;
    assign is_new_move = (kind == KIND_MOVE);

    assign mv_dir   = is_new_move ? new_dir   : dir_reg;
    assign mv_total = is_new_move ? new_total : steps_total_reg;
    assign mv_count = is_new_move ? 8'd0      : step_count_reg;
    assign mv_decel = is_new_move ? 4'd0      : decel_idx_reg;
    assign mv_left  = mv_total - mv_count;

    // Ramp delay: acceleration first, then deceleration near the end, cruise between.
    assign dec_k       = (mv_decel > DECEL_IDX_LAST) ? DECEL_IDX_LAST : mv_decel;
    assign mv_in_decel = (mv_count >= ACCEL_STEPS) && (mv_left < DECEL_WINDOW);
    always_comb begin
        if (mv_count < ACCEL_STEPS) begin
            mv_wait = ACCEL_TABLE[mv_count[ACCEL_IDX_W-1:0]];
        end else if (mv_left < DECEL_WINDOW) begin
            mv_wait = DECEL_TABLE[dec_k];
        end else begin
            mv_wait = CRUISE_DELAY;
        end
    end

    assign mv_phase   = mv_dir ? (phase_reg + 2'd1) : (phase_reg - 2'd1);
    assign home_phase = phase_reg + 2'd1;

    // Command decode and step sequencing for the accepted beat.
    always_comb begin
        phase_next       = phase_reg;
        bin_next         = bin_reg;
        home_seen_next   = home_seen_reg;
        mode_next        = mode_reg;
        dir_next         = dir_reg;
        steps_total_next = steps_total_reg;
        step_count_next  = step_count_reg;
        decel_idx_next   = decel_idx_reg;
        wait_next        = wait_reg;
        res_valid        = 1'b0;
        res_coil         = COIL_TABLE[phase_reg];
        res_belt         = 1'b0;
        res_last         = 1'b0;
        res_bin          = bin_reg;
        if (s_accept) begin
            unique case (kind)
                KIND_SENSOR: begin
                    home_seen_next = 1'b1;
                end
                KIND_MOVE: begin
                    if ((mode_reg == MODE_IDLE) && (target != bin_reg)) begin
                        dir_next         = new_dir;
                        steps_total_next = new_total;
                        bin_next         = target;
                        step_count_next  = 8'd0;
                        decel_idx_next   = 4'd0;
                        wait_next        = 9'd0;
                        if (new_total != 8'd0) begin
                            mode_next = MODE_MOVE;
                            res_valid = 1'b1;
                        end
                    end
                end
                KIND_HOME: begin
                    if (mode_reg == MODE_IDLE) begin
                        if (home_seen_reg) begin
                            bin_next = 2'd0;
                        end else begin
                            mode_next = MODE_HOME;
                            res_valid = 1'b1;
                        end
                    end
                end
                KIND_TICK: begin
                    if (mode_reg != MODE_IDLE) begin
                        if (wait_reg > 9'd1) begin
                            wait_next = wait_reg - 9'd1;
                        end else begin
                            wait_next = 9'd0;
                            if (mode_reg == MODE_MOVE) begin
                                if (step_count_reg < steps_total_reg) begin
                                    res_valid = 1'b1;
                                end else begin
                                    mode_next = MODE_IDLE;
                                end
                            end else if (home_seen_reg) begin
                                bin_next  = 2'd0;
                                mode_next = MODE_IDLE;
                            end else begin
                                res_valid = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase

            // Take the step that the command or tick called for.
            if (res_valid) begin
                res_bin = bin_next;
                if (mode_next == MODE_MOVE) begin
                    phase_next      = mv_phase;
                    res_coil        = COIL_TABLE[mv_phase];
                    res_belt        = (mv_left < belt_lead_reg);
                    res_last        = (mv_left == 8'd1);
                    wait_next       = mv_wait;
                    step_count_next = mv_count + 8'd1;
                    decel_idx_next  = mv_decel;
                    if (mv_in_decel && (mv_decel < DECEL_IDX_MAX)) begin
                        decel_idx_next = mv_decel + 4'd1;
                    end
                end else begin
                    phase_next = home_phase;
                    res_coil   = COIL_TABLE[home_phase];
                    wait_next  = home_delay_reg;
                end
            end
        end
    end

    // Stepper state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= 2'd0;
            bin_reg         <= 2'd0;
            home_seen_reg   <= 1'b0;
            mode_reg        <= MODE_IDLE;
            dir_reg         <= 1'b0;
            steps_total_reg <= 8'd0;
            step_count_reg  <= 8'd0;
            decel_idx_reg   <= 4'd0;
            wait_reg        <= 9'd0;
        end else begin
            phase_reg       <= phase_next;
            bin_reg         <= bin_next;
            home_seen_reg   <= home_seen_next;
            mode_reg        <= mode_next;
            dir_reg         <= dir_next;
            steps_total_reg <= steps_total_next;
            step_count_reg  <= step_count_next;
            decel_idx_reg   <= decel_idx_next;
            wait_reg        <= wait_next;
        end
    end

    // Output buffer valid flags: the skid slot fills only when the main slot is stalled.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_pop) begin
            out_valid_reg  <= skid_valid_reg || res_valid;
            skid_valid_reg <= 1'b0;
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output buffer payload.
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_pop) begin
            if (skid_valid_reg) begin
                out_coil_reg <= skid_coil_reg;
                out_belt_reg <= skid_belt_reg;
                out_last_reg <= skid_last_reg;
                out_bin_reg  <= skid_bin_reg;
            end else begin
                out_coil_reg <= res_coil;
                out_belt_reg <= res_belt;
                out_last_reg <= res_last;
                out_bin_reg  <= res_bin;
            end
        end else if (res_valid && !skid_valid_reg) begin
            skid_coil_reg <= res_coil;
            skid_belt_reg <= res_belt;
            skid_last_reg <= res_last;
            skid_bin_reg  <= res_bin;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_bin_reg, out_belt_reg, out_coil_reg};
    assign m_tlast  = out_last_reg;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quarter_steps_reg <= QUARTER_STEPS_RST;
            half_steps_reg    <= HALF_STEPS_RST;
            belt_lead_reg     <= BELT_LEAD_RST;
            home_delay_reg    <= HOME_DELAY_RST;
        end else if (cfg_write) begin
            unique case (reg_index_t'(paddr[3:2]))
                REG_QUARTER_STEPS: quarter_steps_reg <= pwdata[7:0];
                REG_HALF_STEPS:    half_steps_reg    <= pwdata[7:0];
                REG_BELT_LEAD:     belt_lead_reg     <= pwdata[7:0];
                REG_HOME_DELAY:    home_delay_reg    <= pwdata[8:0];
                default: begin
                end
            endcase
        end
    end

    // Configuration register read back.
    always_comb begin
        unique case (reg_index_t'(paddr[3:2]))
            REG_QUARTER_STEPS: prdata = {24'd0, quarter_steps_reg};
            REG_HALF_STEPS:    prdata = {24'd0, half_steps_reg};
            REG_BELT_LEAD:     prdata = {24'd0, belt_lead_reg};
            REG_HOME_DELAY:    prdata = {23'd0, home_delay_reg};
            default:           prdata = 32'd0;
        endcase
    end

`ifndef SYNTHESIS
    // The skid slot holds a beat only behind a full main slot.
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot full while main slot empty");

    // A running move never counts past its length.
    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_MOVE) |-> (step_count_reg <= steps_total_reg))
        else $error("step count beyond move length");

    // A sensor event always leaves the home flag set.
    a_sensor_sets_home: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (kind == KIND_SENSOR)) |=> home_seen_reg)
        else $error("sensor event did not set home flag");

    // A step beat from a homing run never carries move flags.
    a_home_step_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && (mode_next == MODE_HOME)) |-> (!res_belt && !res_last))
        else $error("homing step carries move flags");
`endif

endmodule
